>>> rtl/cqs_pkg.sv
// ----------------------------------------------------------------------------
// cqs_pkg
// Shared sizes, codes, state and command types of the circular queue core.
// ----------------------------------------------------------------------------
package cqs_pkg;

    localparam int DEPTH  = 8;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int SLOT_W = 4;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT,
        REQ_DELETE,
        REQ_DISPLAY,
        REQ_SEARCH
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_FULL,
        STAT_EMPTY,
        STAT_NOT_FOUND
    } t_status;

    typedef enum logic [1:0] {
        OUT_STATUS,
        OUT_DELETE,
        OUT_DISPLAY,
        OUT_MATCH
    } t_out_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT,
        ST_DELETE,
        ST_DISPLAY,
        ST_SEARCH,
        ST_SEARCH_END
    } t_state;

    typedef struct packed {
        logic     req_load;
        t_status  code;
        logic     ins_write;
        logic     head_adv;
        logic     walk_start;
        logic     walk_adv;
        logic     rd_en;
        logic     pend_set;
        logic     pend_clr;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic walk_last;
        logic match;
        logic pend_valid;
        logic out_free;
    } t_stat;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = idx + IDX_W'(1);
        end
        return nxt;
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] s;
        s = {1'b0, idx} + (IDX_W+1)'(1);
        return SLOT_W'(s);
    endfunction

endpackage

>>> rtl/cqs_ram.sv
// ----------------------------------------------------------------------------
// cqs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/cqs_ctrl.sv
// ----------------------------------------------------------------------------
// cqs_ctrl
// Request sequencer: decodes each transaction and steps the datapath.
// ----------------------------------------------------------------------------
module cqs_ctrl
    import cqs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_in_stall,
    input  t_stat            i_stat,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.req_load = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                    case (t_req'(i_req_type))
                        REQ_INSERT: begin
                            o_cmd.code      = i_stat.full ? STAT_FULL : STAT_OK;
                            o_cmd.ins_write = !i_stat.full;
                            n_state         = ST_EMIT;
                        end
                        REQ_DELETE: begin
                            o_cmd.code = STAT_EMPTY;
                            if (i_stat.empty) begin
                                n_state = ST_EMIT;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                n_state     = ST_DELETE;
                            end
                        end
                        REQ_DISPLAY: begin
                            o_cmd.code = STAT_EMPTY;
                            if (i_stat.empty) begin
                                n_state = ST_EMIT;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                o_cmd.rd_en      = 1'b1;
                                n_state          = ST_DISPLAY;
                            end
                        end
                        REQ_SEARCH: begin
                            o_cmd.code = STAT_NOT_FOUND;
                            if (i_stat.empty) begin
                                n_state = ST_EMIT;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                o_cmd.rd_en      = 1'b1;
                                n_state          = ST_SEARCH;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_STATUS;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_DELETE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DELETE;
                    o_cmd.out_last = 1'b1;
                    o_cmd.head_adv = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_DISPLAY: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OUT_DISPLAY;
                    o_cmd.out_last = i_stat.walk_last;
                    if (i_stat.walk_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.walk_adv = 1'b1;
                        o_cmd.rd_en    = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                // hold a match until the next one shows it was not the final one
                if (!i_stat.match || !i_stat.pend_valid || i_stat.out_free) begin
                    o_cmd.walk_adv = 1'b1;
                    o_cmd.rd_en    = 1'b1;
                    if (i_stat.match) begin
                        o_cmd.pend_set = 1'b1;
                        if (i_stat.pend_valid) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_sel  = OUT_MATCH;
                        end
                    end
                    if (i_stat.walk_last) begin
                        n_state = ST_SEARCH_END;
                    end
                end
            end
            ST_SEARCH_END: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = i_stat.pend_valid ? OUT_MATCH : OUT_STATUS;
                    o_cmd.out_last = 1'b1;
                    o_cmd.pend_clr = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/cqs_dp.sv
// ----------------------------------------------------------------------------
// cqs_dp
// Queue datapath: pointers, entry count, storage, walk counter, pending
// search match and the output register.
// ----------------------------------------------------------------------------
module cqs_dp
    import cqs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [DATA_W-1:0] i_value,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [SLOT_W-1:0]        o_slot,
    output logic                     o_last
);

    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_walk_idx;
    logic [CNT_W-1:0]  r_walk_left;
    logic [DATA_W-1:0] r_key;
    t_status           r_code;
    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_pend_slot;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_data;
    logic [SLOT_W-1:0] r_slot;
    logic              r_last;

    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              out_free;
    logic [STAT_W-1:0] n_status;
    logic [DATA_W-1:0] n_data;
    logic [SLOT_W-1:0] n_slot;

    assign rd_addr  = i_cmd.walk_adv ? advance(r_walk_idx) : r_head;
    assign out_free = !r_out_valid || !i_out_stall;

    cqs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.ins_write),
        .i_wr_addr(r_tail),
        .i_wr_data(i_value),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.ins_write) begin
                r_tail  <= advance(r_tail);
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.head_adv) begin
                r_head  <= advance(r_head);
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_key  <= i_value;
            r_code <= i_cmd.code;
        end
        if (i_cmd.walk_start) begin
            r_walk_idx  <= r_head;
            r_walk_left <= r_count;
        end else if (i_cmd.walk_adv) begin
            r_walk_idx  <= advance(r_walk_idx);
            r_walk_left <= r_walk_left - CNT_W'(1);
        end
        if (i_cmd.pend_set) begin
            r_pend_slot <= to_slot(r_walk_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.pend_set) begin
            r_pend_valid <= 1'b1;
        end else if (i_cmd.pend_clr) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_comb begin
        n_status = STAT_OK;
        n_data   = '0;
        n_slot   = '0;
        case (i_cmd.out_sel)
            OUT_STATUS: begin
                n_status = r_code;
            end
            OUT_DELETE: begin
                n_data = rd_data;
            end
            OUT_DISPLAY: begin
                n_data = rd_data;
                n_slot = to_slot(r_walk_idx);
            end
            OUT_MATCH: begin
                n_slot = r_pend_slot;
            end
            default: begin
                n_status = r_code;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_slot   <= n_slot;
            r_last   <= i_cmd.out_last;
        end
    end

    assign o_stat.full       = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty      = (r_count == '0);
    assign o_stat.walk_last  = (r_walk_left == CNT_W'(1));
    assign o_stat.match      = (rd_data == r_key);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_slot      = r_slot;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten while held");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk_adv |-> (r_walk_left != '0))
        else $error("walk ran past the occupied range");

    a_no_full_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write |-> !o_stat.full && !i_cmd.head_adv)
        else $error("insert into full queue or with a delete");

    a_delete_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.head_adv |-> !o_stat.empty)
        else $error("delete from empty queue");
`endif

endmodule

>>> rtl/circular_queue_with_search_core.sv
// ----------------------------------------------------------------------------
// circular_queue_with_search_core
// Circular queue of signed words with insert, delete, display and search.
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+----------------------------------
//   request | i_in_valid   | o_in_stall   | i_req_type, i_value
//   result  | o_out_valid  | i_out_stall  | o_status, o_data, o_slot, o_last
//
// Insert, delete and any request on an empty queue give a single result.
// Display and search walk the entries in order, one storage read per entry
// through the single RAM read port. Reset is synchronous and active low;
// the storage itself is not cleared. A stalled result holds the output
// register; display waits for it, search only when it has a match to emit.
// ----------------------------------------------------------------------------
module circular_queue_with_search_core
    import cqs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [REQ_W-1:0]         i_req_type,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_data,
    output logic [SLOT_W-1:0]        o_slot,
    output logic                     o_last
);

    t_cmd  cmd;
    t_stat stat;

    cqs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_req_type),
        .o_in_stall(o_in_stall),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    cqs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_out_stall(i_out_stall),
        .o_out_valid(o_out_valid),
        .o_status   (o_status),
        .o_data     (o_data),
        .o_slot     (o_slot),
        .o_last     (o_last)
    );

endmodule
